[rtl/rme_pkg.sv]
package rme_pkg;

    // operand and angle widths
    localparam int MAT_W   = 16;
    localparam int OP_W    = 17;
    localparam int SQRT_W  = 30;
    localparam int CORD_W  = 34;
    localparam int ANG_W   = 28;
    localparam int OUT_W   = 16;
    localparam int THR_W   = 15;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    // angle scale: 2^24 per radian
    localparam logic signed [ANG_W-1:0] ANG_PI    = 28'sd52707179;
    localparam logic signed [OUT_W:0]   OUT_LIMIT = 17'sd25736;
    localparam logic signed [ANG_W-1:0] ROUND_ADD = 28'sd1024;
    localparam int FRAC_DROP = 11;

    // matrix entries of one item
    typedef struct packed {
        logic signed [MAT_W-1:0] m00;
        logic signed [MAT_W-1:0] m10;
        logic signed [MAT_W-1:0] m20;
        logic signed [MAT_W-1:0] m21;
        logic signed [MAT_W-1:0] m22;
        logic signed [MAT_W-1:0] m12;
        logic signed [MAT_W-1:0] m11;
    } mat_t;

    // classified item between front and back
    typedef struct packed {
        logic                   sing;
        logic signed [OP_W-1:0] pitch_y;
        logic [SQRT_W-1:0]      sy;
        logic signed [OP_W-1:0] roll_y;
        logic signed [OP_W-1:0] roll_x;
        logic signed [OP_W-1:0] yaw_y;
        logic signed [OP_W-1:0] yaw_x;
    } entry_t;

    // arctangent of 2^-i in angle units
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0: a = 28'sd13176795;
            1: a = 28'sd7778716;
            2: a = 28'sd4110060;
            3: a = 28'sd2086331;
            4: a = 28'sd1047214;
            5: a = 28'sd524117;
            6: a = 28'sd262123;
            7: a = 28'sd131069;
            8: a = 28'sd65536;
            9: a = 28'sd32768;
            default: a = (i < 25) ? (ANG_W'(1) << (24 - i)) : '0;
        endcase
        return a;
    endfunction

endpackage

[rtl/rme_mat_if.sv]
interface rme_mat_if;
    logic valid;
    logic ready;
    logic signed [15:0] m00;
    logic signed [15:0] m10;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] m12;
    logic signed [15:0] m11;

    modport source (output valid, m00, m10, m20, m21, m22, m12, m11, input ready);
    modport sink (input valid, m00, m10, m20, m21, m22, m12, m11, output ready);
    modport monitor (input valid, ready, m00, m10, m20, m21, m22, m12, m11);
endinterface

[rtl/rme_ang_if.sv]
interface rme_ang_if;
    logic valid;
    logic ready;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic is_singular;

    modport source (output valid, roll, pitch, yaw, is_singular, input ready);
    modport sink (input valid, roll, pitch, yaw, is_singular, output ready);
    modport monitor (input valid, ready, roll, pitch, yaw, is_singular);
endinterface

[rtl/rme_front.sv]
module rme_front (
    input  logic                          clk,
    input  logic                          rst_n,
    rme_mat_if.sink                       matrix,
    input  logic [rme_pkg::THR_W-1:0]     threshold,
    input  logic                          q_full,
    output logic                          cls_valid,
    output rme_pkg::entry_t               cls_entry
);

    localparam int SW   = rme_pkg::SQRT_W;
    localparam int NSTG = SW + 3;

    logic [NSTG-1:0]   v_reg;
    logic              adv;
    rme_pkg::mat_t     mat_in;
    rme_pkg::mat_t     mat_reg [0:NSTG-2];
    logic [30:0]       sq0_reg;
    logic [30:0]       sq1_reg;
    logic [31:0]       sum_reg [1:NSTG-2];
    logic [31:0]       rem_reg [1:NSTG-2];
    logic [SW-1:0]     root_reg [1:NSTG-2];
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic [15:0]       sy14;
    logic              sing;
    rme_pkg::entry_t   cls_next;
    rme_pkg::entry_t   cls_reg;

    // whole front moves unless the finished item cannot enter the queue
    assign adv          = !(v_reg[NSTG-1] && q_full);
    assign matrix.ready = adv;
    assign cls_valid    = v_reg[NSTG-1];
    assign cls_entry    = cls_reg;

    always_comb
    begin
        mat_in.m00 = matrix.m00;
        mat_in.m10 = matrix.m10;
        mat_in.m20 = matrix.m20;
        mat_in.m21 = matrix.m21;
        mat_in.m22 = matrix.m22;
        mat_in.m12 = matrix.m12;
        mat_in.m11 = matrix.m11;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTG-2:0], matrix.valid};
        end
    end

    // squares, then their sum
    assign p0 = matrix.m00 * matrix.m00;
    assign p1 = matrix.m10 * matrix.m10;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat_reg[0]  <= mat_in;
            sq0_reg     <= p0[30:0];
            sq1_reg     <= p1[30:0];
            mat_reg[1]  <= mat_reg[0];
            sum_reg[1]  <= {1'b0, sq0_reg} + {1'b0, sq1_reg};
            rem_reg[1]  <= '0;
            root_reg[1] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SW; j++)
    begin : g_sqrt
        localparam int K = SW - 1 - j;
        logic [1:0]  pr;
        logic [33:0] rs;
        logic [33:0] tr;
        logic [33:0] df;

        if (K >= 14)
        begin : g_bits
            assign pr = sum_reg[1+j][2*K-27 -: 2];
        end
        else
        begin : g_zero
            assign pr = 2'b00;
        end

        assign rs = {rem_reg[1+j], pr};
        assign tr = {2'b00, root_reg[1+j], 2'b01};
        assign df = rs - tr;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mat_reg[2+j] <= mat_reg[1+j];
                sum_reg[2+j] <= sum_reg[1+j];
                if (rs >= tr)
                begin
                    rem_reg[2+j]  <= df[31:0];
                    root_reg[2+j] <= {root_reg[1+j][SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[2+j]  <= rs[31:0];
                    root_reg[2+j] <= {root_reg[1+j][SW-2:0], 1'b0};
                end
            end
        end
    end

    // classify: singular test and operand choice
    always_comb
    begin
        sy14             = root_reg[NSTG-2][SW-1:14];
        sing             = sy14 < {1'b0, threshold};
        cls_next.sing    = sing;
        cls_next.sy      = root_reg[NSTG-2];
        cls_next.pitch_y = -(17'(mat_reg[NSTG-2].m20));
        cls_next.yaw_y   = 17'(mat_reg[NSTG-2].m10);
        cls_next.yaw_x   = 17'(mat_reg[NSTG-2].m00);
        if (sing)
        begin
            cls_next.roll_y = -(17'(mat_reg[NSTG-2].m12));
            cls_next.roll_x = 17'(mat_reg[NSTG-2].m11);
        end
        else
        begin
            cls_next.roll_y = 17'(mat_reg[NSTG-2].m21);
            cls_next.roll_x = 17'(mat_reg[NSTG-2].m22);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

[rtl/rme_queue.sv]
module rme_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rme_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output rme_pkg::entry_t pop_data,
    output logic            nonempty
);

    localparam int PW = rme_pkg::QPTR_W;

    rme_pkg::entry_t mem_reg [0:rme_pkg::QDEPTH-1];
    logic [PW-1:0]   wr_reg;
    logic [PW-1:0]   rd_reg;
    logic [PW:0]     cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full     = cnt_reg == (PW+1)'(rme_pkg::QDEPTH);
    assign nonempty = cnt_reg != '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign pop_data = mem_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

[rtl/rme_cordic.sv]
module rme_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [rme_pkg::CORD_W-1:0]   y_in,
    input  logic signed [rme_pkg::CORD_W-1:0]   x_in,
    input  logic                                zero_in,
    output logic signed [rme_pkg::OUT_W-1:0]    angle
);

    localparam int CW = rme_pkg::CORD_W;
    localparam int AW = rme_pkg::ANG_W;
    localparam int OW = rme_pkg::OUT_W;

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [AW-1:0] z_reg [0:STEPS];
    logic                 zf_reg [0:STEPS];
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [AW-1:0] z0;
    logic signed [AW-1:0] zr;
    logic signed [OW:0]   q;
    logic signed [OW:0]   qc;
    logic signed [OW-1:0] angle_reg;

    // quadrant fold for negative x
    always_comb
    begin
        if (x_in < 0)
        begin
            x0 = -x_in;
            y0 = -y_in;
            z0 = (y_in >= 0) ? rme_pkg::ANG_PI : -rme_pkg::ANG_PI;
        end
        else
        begin
            x0 = x_in;
            y0 = y_in;
            z0 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x0;
            y_reg[0]  <= y0;
            z_reg[0]  <= z0;
            zf_reg[0] <= zero_in;
        end
    end

    // one rotation per stage
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [AW-1:0] AT = rme_pkg::atan_step(i);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zf_reg[i+1] <= zf_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + AT;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - AT;
                end
            end
        end
    end

    // round to output scale and clamp
    always_comb
    begin
        zr = z_reg[STEPS] + rme_pkg::ROUND_ADD;
        q  = zr[AW-1:rme_pkg::FRAC_DROP];
        if (zf_reg[STEPS])
        begin
            qc = '0;
        end
        else if (q > rme_pkg::OUT_LIMIT)
        begin
            qc = rme_pkg::OUT_LIMIT;
        end
        else if (q < -rme_pkg::OUT_LIMIT)
        begin
            qc = -rme_pkg::OUT_LIMIT;
        end
        else
        begin
            qc = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= qc[OW-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

[rtl/rme_back.sv]
module rme_back #(
    parameter int STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_nonempty,
    input  rme_pkg::entry_t q_data,
    output logic            q_pop,
    rme_ang_if.source       angles
);

    localparam int L  = STEPS + 2;
    localparam int CW = rme_pkg::CORD_W;

    logic [L-1:0]         v_reg;
    logic                 sing_reg [0:L-1];
    logic                 adv;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] wy;
    logic signed [CW-1:0] wx;
    logic                 pz;
    logic                 rz;
    logic                 wz;

    assign adv   = !v_reg[L-1] || angles.ready;
    assign q_pop = q_nonempty && adv;

    // operands brought to Q.28
    assign py = {{3{q_data.pitch_y[16]}}, q_data.pitch_y, 14'b0};
    assign px = {4'b0, q_data.sy};
    assign ry = {{3{q_data.roll_y[16]}}, q_data.roll_y, 14'b0};
    assign rx = {{3{q_data.roll_x[16]}}, q_data.roll_x, 14'b0};
    assign wy = {{3{q_data.yaw_y[16]}}, q_data.yaw_y, 14'b0};
    assign wx = {{3{q_data.yaw_x[16]}}, q_data.yaw_x, 14'b0};
    assign pz = (q_data.pitch_y == '0) && (q_data.sy == '0);
    assign rz = (q_data.roll_y == '0) && (q_data.roll_x == '0);
    assign wz = q_data.sing || ((q_data.yaw_y == '0) && (q_data.yaw_x == '0));

    // valid bits of the angle pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[L-2:0], q_pop};
        end
    end

    // singular flag follows its item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sing_reg[0] <= q_data.sing;
            for (int k = 1; k < L; k++)
            begin
                sing_reg[k] <= sing_reg[k-1];
            end
        end
    end

    rme_cordic #(.STEPS(STEPS)) u_roll (
        .clk     (clk),
        .en      (adv),
        .y_in    (ry),
        .x_in    (rx),
        .zero_in (rz),
        .angle   (angles.roll)
    );

    rme_cordic #(.STEPS(STEPS)) u_pitch (
        .clk     (clk),
        .en      (adv),
        .y_in    (py),
        .x_in    (px),
        .zero_in (pz),
        .angle   (angles.pitch)
    );

    rme_cordic #(.STEPS(STEPS)) u_yaw (
        .clk     (clk),
        .en      (adv),
        .y_in    (wy),
        .x_in    (wx),
        .zero_in (wz),
        .angle   (angles.yaw)
    );

    assign angles.valid       = v_reg[L-1];
    assign angles.is_singular = sing_reg[L-1];

endmodule

[rtl/rotation_matrix_to_euler.sv]
// channel   | dir | handshake    | payload
// matrix    | in  | valid/ready  | m00 m10 m20 m21 m22 m12 m11, signed Q2.14
// angles    | out | valid/ready  | roll pitch yaw (signed Q3.13 rad), is_singular
// cfg       | in  | cfg_we       | cfg_wdata: singular_threshold, Q2.14 units
//
// one item per cycle sustained unless a stalled output fills the queue;
// 36 + CORDIC_STEPS register stages, the first loaded at the accepting edge
// (33 stages of squares, sum, bit-per-stage square root and classify, one
// queue stage, then fold, CORDIC_STEPS rotations and rounding)
// reset clears all valid bits and the queue, threshold returns to 1
// a stalled output holds the angle pipeline; the four-entry queue lets the
// front keep accepting until it fills
module rotation_matrix_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rme_mat_if.sink     matrix,
    rme_ang_if.source   angles,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata
);

    logic [rme_pkg::THR_W-1:0] thr_reg;
    logic                      q_full;
    logic                      cls_valid;
    rme_pkg::entry_t           cls_entry;
    logic                      q_pop;
    logic                      q_nonempty;
    rme_pkg::entry_t           q_data;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 15'd1;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    rme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .matrix    (matrix),
        .threshold (thr_reg),
        .q_full    (q_full),
        .cls_valid (cls_valid),
        .cls_entry (cls_entry)
    );

    rme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cls_valid),
        .push_data (cls_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .nonempty  (q_nonempty)
    );

    rme_back #(.STEPS(CORDIC_STEPS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .angles     (angles)
    );

endmodule

[rtl/rme_checker.sv]
module rme_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic [14:0]        cfg_wdata,
    input logic               valid,
    input logic               ready,
    input logic signed [15:0] roll,
    input logic signed [15:0] pitch,
    input logic signed [15:0] yaw,
    input logic               is_singular
);

    logic [14:0] thr_reg;

    // mirror of the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 15'd1;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // a waiting item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(roll)
        && $stable(pitch) && $stable(yaw))
        else $error("output item changed while stalled");

    // singular items carry no yaw
    a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_singular |-> yaw == 16'sd0)
        else $error("yaw not zero on singular item");

    // zero threshold never flags
    a_thr: assert property (@(posedge clk) disable iff (!rst_n)
        valid && thr_reg == 15'd0 |-> !is_singular)
        else $error("singular with zero threshold");

    // angles stay inside the clamp
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> roll <= 16'sd25736 && roll >= -16'sd25736
        && yaw <= 16'sd25736 && yaw >= -16'sd25736
        && pitch <= 16'sd25736 && pitch >= -16'sd25736)
        else $error("angle outside clamp");

endmodule

bind rotation_matrix_to_euler rme_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .valid       (angles.valid),
    .ready       (angles.ready),
    .roll        (angles.roll),
    .pitch       (angles.pitch),
    .yaw         (angles.yaw),
    .is_singular (angles.is_singular)
);

[tb/rotation_matrix_to_euler_tb.sv]
`timescale 1ns / 1ps

module rotation_matrix_to_euler_tb;

    localparam int STEPS    = 16;
    localparam int LATENCY  = 37 + STEPS;
    localparam longint PI_Q24 = 64'sd52707179;
    localparam longint ANGLE_CLAMP = 64'sd25736;

    // one expected set of angles
    typedef struct packed {
        logic signed [rme_pkg::OUT_W-1:0] roll;
        logic signed [rme_pkg::OUT_W-1:0] pitch;
        logic signed [rme_pkg::OUT_W-1:0] yaw;
        logic                             sing;
    } angles_t;

    // one directed row
    typedef struct {
        rme_pkg::mat_t mat;
        bit            typed;
        angles_t       want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rme_pkg::THR_W-1:0] cfg_wdata;

    rme_mat_if mat_bus ();
    rme_ang_if ang_bus ();

    rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .matrix    (mat_bus),
        .angles    (ang_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    angles_t     pending_angles[$];
    logic [rme_pkg::THR_W-1:0] threshold_now;
    int          fail_count;
    int          items_sent;
    int          results_seen;
    int          singular_seen;
    int          stall_left;
    bit          rx_no_stall;

    // arctangent of 2^-i, 2^24 per radian
    function automatic longint atan_of_step(input int i);
        longint lut[10] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                            524117, 262123, 131069, 65536, 32768};
        if (i < 10)
            return lut[i];
        return longint'(1) << (24 - i);
    endfunction

    // floor square root, bit by bit
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, result in Q3.13 with clamp
    function automatic logic signed [rme_pkg::OUT_W-1:0] arc_angle(input longint y,
                                                                   input longint x);
        longint z;
        longint xs;
        longint ys;
        longint q;
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q24 : -PI_Q24;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_of_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_of_step(i);
            end
        end
        q = (z + 1024) >>> 11;
        if (q > ANGLE_CLAMP)
            q = ANGLE_CLAMP;
        if (q < -ANGLE_CLAMP)
            q = -ANGLE_CLAMP;
        return q[rme_pkg::OUT_W-1:0];
    endfunction

    // euler angles of one matrix under the current threshold
    function automatic angles_t euler_of(input rme_pkg::mat_t m,
                                         input logic [rme_pkg::THR_W-1:0] thr);
        angles_t a;
        longint  e00;
        longint  e10;
        longint unsigned sy28;
        e00 = m.m00;
        e10 = m.m10;
        sy28 = root_floor(longint'(e00 * e00 + e10 * e10) << 28);
        a.sing = (sy28 >> 14) < thr;
        a.pitch = arc_angle(-longint'(m.m20) * 16384, sy28);
        if (!a.sing)
        begin
            a.roll = arc_angle(longint'(m.m21) * 16384, longint'(m.m22) * 16384);
            a.yaw = arc_angle(e10 * 16384, e00 * 16384);
        end
        else
        begin
            a.roll = arc_angle(-longint'(m.m12) * 16384, longint'(m.m11) * 16384);
            a.yaw = '0;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("[rotation_matrix_to_euler] ERROR");
        $finish;
    end

    // receiver: random stalls, mostly short
    initial
    begin
        ang_bus.ready = 1'b0;
        stall_left = 0;
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            ang_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            ang_bus.ready <= 1'b1;
            if (!rx_no_stall && $urandom_range(0, 3) == 0)
                stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                           : $urandom_range(1, 3);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        angles_t w;
        if (rst_n && ang_bus.valid && ang_bus.ready)
        begin
            results_seen++;
            if (pending_angles.size() == 0)
            begin
                report_mismatch("unexpected result count", 1, 0);
            end
            else
            begin
                w = pending_angles.pop_front();
                if (w.sing)
                    singular_seen++;
                if (ang_bus.roll !== w.roll)
                    report_mismatch("roll", ang_bus.roll, w.roll);
                if (ang_bus.pitch !== w.pitch)
                    report_mismatch("pitch", ang_bus.pitch, w.pitch);
                if (ang_bus.yaw !== w.yaw)
                    report_mismatch("yaw", ang_bus.yaw, w.yaw);
                if (ang_bus.is_singular !== w.sing)
                    report_mismatch("is_singular", ang_bus.is_singular, w.sing);
            end
        end
    end

    // present one matrix, hold until taken, then maybe idle
    task automatic send_matrix(input rme_pkg::mat_t m, input bit typed, input angles_t want,
                               input bit no_gap);
        int gap;
        mat_bus.valid <= 1'b1;
        mat_bus.m00 <= m.m00;
        mat_bus.m10 <= m.m10;
        mat_bus.m20 <= m.m20;
        mat_bus.m21 <= m.m21;
        mat_bus.m22 <= m.m22;
        mat_bus.m12 <= m.m12;
        mat_bus.m11 <= m.m11;
        forever
        begin
            @(posedge clk);
            if (mat_bus.ready)
                break;
        end
        pending_angles.insert(pending_angles.size(),
                              typed ? want : euler_of(m, threshold_now));
        items_sent++;
        gap = 0;
        if (!no_gap && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            mat_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for every result, then let the pipeline drain
    task automatic drain_all();
        mat_bus.valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [rme_pkg::THR_W-1:0] v);
        drain_all();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_now = v;
    endtask

    function automatic logic signed [rme_pkg::MAT_W-1:0] pick_entry(input int mode,
                                                                    input int span);
        if (mode == 0)
            return rme_pkg::MAT_W'($urandom());
        return rme_pkg::MAT_W'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // random matrix: full range, rotation-like, or near gimbal lock
    function automatic rme_pkg::mat_t random_matrix(input logic [rme_pkg::THR_W-1:0] thr);
        rme_pkg::mat_t m;
        int   kind;
        int   near;
        kind = $urandom_range(0, 9);
        near = (thr > 16384) ? 16384 : thr + 2;
        m.m20 = pick_entry(kind >= 7 ? 0 : 1, 16384);
        m.m21 = pick_entry(kind >= 7 ? 0 : 1, 16384);
        m.m22 = pick_entry(kind >= 7 ? 0 : 1, 16384);
        m.m12 = pick_entry(kind >= 7 ? 0 : 1, 16384);
        m.m11 = pick_entry(kind >= 7 ? 0 : 1, 16384);
        if (kind >= 7)
        begin
            m.m00 = pick_entry(0, 0);
            m.m10 = pick_entry(0, 0);
        end
        else if (kind >= 5)
        begin
            m.m00 = pick_entry(1, near);
            m.m10 = pick_entry(1, near);
        end
        else
        begin
            m.m00 = pick_entry(1, 16384);
            m.m10 = pick_entry(1, 16384);
        end
        return m;
    endfunction

    stim_row_t rows[$];

    function automatic stim_row_t row(input int a, input int b, input int c, input int d,
                                      input int e, input int f, input int g);
        stim_row_t r;
        r.mat = '{rme_pkg::MAT_W'(a), rme_pkg::MAT_W'(b), rme_pkg::MAT_W'(c),
                  rme_pkg::MAT_W'(d), rme_pkg::MAT_W'(e), rme_pkg::MAT_W'(f),
                  rme_pkg::MAT_W'(g)};
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    initial
    begin
        stim_row_t r;
        angles_t   none;
        logic [rme_pkg::THR_W-1:0] thr_plan[6];
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mat_bus.valid = 1'b0;
        mat_bus.m00 = '0;
        mat_bus.m10 = '0;
        mat_bus.m20 = '0;
        mat_bus.m21 = '0;
        mat_bus.m22 = '0;
        mat_bus.m12 = '0;
        mat_bus.m11 = '0;
        rx_no_stall = 1'b0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        singular_seen = 0;
        threshold_now = rme_pkg::THR_W'(1);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; zero matrix is singular with all angles zero
        r = row(0, 0, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.want = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        rows.insert(rows.size(), r);
        rows.insert(rows.size(), row(16384, 0, 0, 0, 16384, 0, 16384));
        rows.insert(rows.size(), row(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        rows.insert(rows.size(), row(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        rows.insert(rows.size(), row(-32768, 0, 0, 0, -32768, 0, 0));
        rows.insert(rows.size(), row(-16384, -1, 16384, -1, -16384, 0, 0));
        rows.insert(rows.size(), row(0, 16384, -16384, 16384, 0, 0, 0));
        rows.insert(rows.size(), row(0, 0, -16384, 0, 0, 16384, -16384));
        rows.insert(rows.size(), row(0, 0, 16384, 0, 0, -32768, 32767));
        rows.insert(rows.size(), row(1, 0, 32767, 1, 1, 0, 0));
        rows.insert(rows.size(), row(0, -1, -32768, 0, -1, 5, 5));
        rows.insert(rows.size(), row(11585, 11585, 0, 11585, -11585, -100, 100));
        rows.insert(rows.size(), row(-32768, 32767, 1, -32768, 32767, 0, -1));
        rows.insert(rows.size(), row(32767, -32768, -1, 32767, -32768, 1, 0));
        foreach (rows[i])
            send_matrix(rows[i].mat, rows[i].typed, rows[i].want, 1'b0);

        // threshold phases, extremes included
        thr_plan = '{15'd0, 15'd16384, 15'd32767, 15'd1, 15'($urandom_range(2, 2000)),
                     15'($urandom_range(0, 32767))};
        foreach (thr_plan[p])
        begin
            set_threshold(thr_plan[p]);
            if (p == 0)
                foreach (rows[i])
                    send_matrix(rows[i].mat, 1'b0, none, 1'b0);
            rx_no_stall = (p == 2);
            for (int n = 0; n < 245; n++)
            begin
                // one hold-off mid-phase until the pipe is empty
                if (p == 4 && n == 120)
                begin
                    mat_bus.valid <= 1'b0;
                    while (pending_angles.size() != 0)
                        @(posedge clk);
                end
                send_matrix(random_matrix(threshold_now), 1'b0, none, p == 2 && n < 100);
            end
            rx_no_stall = 1'b0;
        end

        mat_bus.valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("covered %0d matrices over 7 threshold settings, %0d results, %0d singular",
                 items_sent, results_seen, singular_seen);
        if (fail_count == 0)
            $display("[rotation_matrix_to_euler] OK");
        else
            $display("[rotation_matrix_to_euler] ERROR");
        $finish;
    end

endmodule
